### design/tpcs_pkg.sv
// tpcs_pkg: shared widths, constants, codes and control structs for the
// three-phase current sense front end. No dependencies; compile first.

package tpcs_pkg;

   // field widths
   localparam int ALPHA_W    = 16;
   localparam int CNT_W      = 16;
   localparam int SCALE_W    = 24;
   localparam int CUR_W      = 21;
   localparam int BUS_W      = 22;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic                  DRIVER_READY_RST  = 1'b1;
   localparam logic [ALPHA_W-1:0]    FILTER_ALPHA_RST  = 16'd15667;
   localparam logic [CNT_W-1:0]      CALIB_SAMPLES_RST = 16'd10000;
   localparam logic [SCALE_W-1:0]    CURRENT_SCALE_RST = 24'd54067;
   localparam logic [SCALE_W-1:0]    VOLT_SCALE_RST    = 24'd148684;
   localparam logic [BUS_W-1:0]      SUPPLY_LIMIT_RST  = 22'd1454899;

   // arithmetic constants
   localparam int Q16_ROUND     = 32768;        // half lsb of a q16 product
   localparam int CUR_ROUND     = 8388608;      // half lsb of a q24 product
   localparam int INTEG_GAIN    = 30270;        // 0.8/sqrt(3) in q0.16
   localparam int INTEG_W       = 15;
   localparam int TRACK_DIVISOR = 100;          // 0.99/0.01 average
   localparam int TRACK_ROUND   = 50;
   localparam int CUR_POS_LIMIT = 1048575;
   localparam int CUR_NEG_LIMIT = 1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DRIVER_READY  = 3'd0,
      REG_FILTER_ALPHA  = 3'd1,
      REG_CALIB_SAMPLES = 3'd2,
      REG_CURRENT_SCALE = 3'd3,
      REG_VOLT_SCALE    = 3'd4,
      REG_SUPPLY_LIMIT  = 3'd5
   } csr_index_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_OFF     = 2'd0,
      PH_CALIB   = 2'd1,
      PH_DONE    = 2'd2,
      PH_MEASURE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FILT,
      ST_PREP,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic mul;
      logic filt;
      logic prep;
      logic div;
      logic fin;
      logic track;
   } lane_ctl_type;

   typedef struct packed {
      logic      bus_mul;
      logic      bus_upd;
      logic      load;
      phase_type phase;
   } merge_ctl_type;

endpackage

### design/tpcs_ifs.sv
// tpcs_ifs: valid/ready channel interfaces for requests, results and
// register writes. Depends on tpcs_pkg.

interface tpcs_req_if #(
   parameter int ADC_BITS = 12
) ();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] sample_a;
   logic [ADC_BITS-1:0] sample_b;
   logic [ADC_BITS-1:0] sample_c;
   logic [ADC_BITS-1:0] sample_bus;

   modport source (output valid, sample_a, sample_b, sample_c, sample_bus, input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, sample_bus, output ready);
endinterface

interface tpcs_rsp_if ();
   logic                                valid;
   logic                                ready;
   logic signed [tpcs_pkg::CUR_W-1:0]   current_a;
   logic signed [tpcs_pkg::CUR_W-1:0]   current_b;
   logic signed [tpcs_pkg::CUR_W-1:0]   current_c;
   logic        [tpcs_pkg::BUS_W-1:0]   bus_volts;
   logic        [tpcs_pkg::BUS_W-1:0]   integ_limit;
   logic        [tpcs_pkg::PHASE_W-1:0] phase;

   modport source (output valid, current_a, current_b, current_c, bus_volts, integ_limit,
                   phase, input ready);
   modport sink (input valid, current_a, current_b, current_c, bus_volts, integ_limit,
                 phase, output ready);
endinterface

interface tpcs_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [tpcs_pkg::CSR_IDX_W-1:0]      index;
   logic [tpcs_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/tpcs_lane.sv
// tpcs_lane: one phase lane - iir low-pass, offset tracker with a reciprocal
// multiply divide by 100, and scaled, saturated current. Depends on tpcs_pkg.

module tpcs_lane #(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tpcs_pkg::lane_ctl_type               ctl,
   input  logic [ADC_BITS-1:0]                  sample,
   input  logic [tpcs_pkg::ALPHA_W-1:0]         alpha,
   input  logic [tpcs_pkg::SCALE_W-1:0]         scale,
   output logic signed [tpcs_pkg::CUR_W-1:0]    current
);

   localparam int SW     = ADC_BITS + FRAC_BITS;
   localparam int LO_W   = SW / 2;
   localparam int HI_W   = SW - LO_W;
   localparam int BETA_W = tpcs_pkg::ALPHA_W + 1;
   localparam int ACC_W  = SW + BETA_W + 1;
   localparam int NW     = SW + 1;
   localparam int QK     = NW + 7;
   localparam int MW     = NW + 1;
   localparam int NLO_W  = NW / 2;
   localparam int NHI_W  = NW - NLO_W;
   localparam int QW     = NW + MW;
   localparam int QUO_W  = QW - QK;
   localparam int PW     = SW + tpcs_pkg::SCALE_W + 1;
   localparam int RW     = (NW > tpcs_pkg::CUR_W + 1) ? NW : tpcs_pkg::CUR_W + 1;
   localparam logic [SW-1:0]     MID_OFFSET = SW'(1) << (SW - 1);
   localparam logic [BETA_W-1:0] ONE_Q16    = BETA_W'(1) << tpcs_pkg::ALPHA_W;
   // ceil(2^QK / 100), gives an exact floor(n / 100) for any n below 2^NW
   localparam logic [MW-1:0]     RECIP_100  =
      MW'(((64'd1 << QK) + 64'(tpcs_pkg::TRACK_DIVISOR - 1))
          / 64'(tpcs_pkg::TRACK_DIVISOR));

   // filter state and offset
   logic [SW-1:0] filt_ff, filt_in;
   logic [SW-1:0] off_ff, off_in;

   // low-pass partial products
   logic [BETA_W-1:0]                        beta;
   logic [tpcs_pkg::ALPHA_W+ADC_BITS-1:0]    px_ff;
   logic [BETA_W+LO_W-1:0]                   plo_ff;
   logic [BETA_W+HI_W-1:0]                   phi_ff;
   logic [ACC_W-1:0]                         acc;

   // tracker divide
   logic signed [SW+1:0] diff;
   logic [NW-1:0]        num_w;
   logic [NW-1:0]        num_ff;
   logic                 dneg_ff;
   logic [NLO_W+MW-1:0]  qlo_ff;
   logic [NHI_W+MW-1:0]  qhi_ff;
   logic [QW-1:0]        qprod;
   logic [QUO_W-1:0]     quot;

   // current path
   logic [SW-1:0]                        mag_ff;
   logic                                 cneg_ff;
   logic [LO_W+tpcs_pkg::SCALE_W-1:0]    clo_ff;
   logic [HI_W+tpcs_pkg::SCALE_W-1:0]    chi_ff;
   logic [PW-1:0]                        prod;
   logic [RW-1:0]                        rnd;
   logic [tpcs_pkg::CUR_W-1:0]           cur_ff, cur_in;

   // filt = (alpha*x + (1-alpha)*filt + 1/2) >> 16
   assign beta    = ONE_Q16 - BETA_W'(alpha);
   assign acc     = (ACC_W'(phi_ff) << LO_W) + ACC_W'(plo_ff)
                  + (ACC_W'(px_ff) << FRAC_BITS) + ACC_W'(tpcs_pkg::Q16_ROUND);
   assign filt_in = acc[tpcs_pkg::ALPHA_W +: SW];

   // floor((filt - off + 50) / 100) taken on magnitudes
   assign diff  = $signed({2'b00, filt_ff}) - $signed({2'b00, off_ff})
                + $signed((SW+2)'(tpcs_pkg::TRACK_ROUND));
   assign num_w = diff[SW+1] ? NW'(-diff + $signed((SW+2)'(tpcs_pkg::TRACK_DIVISOR - 1)))
                             : NW'(diff);

   // quotient from the two registered halves of num * reciprocal
   assign qprod = (QW'(qhi_ff) << NLO_W) + QW'(qlo_ff);
   assign quot  = qprod[QW-1:QK];

   assign off_in = dneg_ff ? off_ff - SW'(quot) : off_ff + SW'(quot);

   // current = round(mag * scale >> 24), saturated to 21 bits
   assign prod = (PW'(chi_ff) << LO_W) + PW'(clo_ff) + PW'(tpcs_pkg::CUR_ROUND);
   assign rnd  = RW'(prod[PW-1:tpcs_pkg::SCALE_W]);

   always_comb begin
      if (!cneg_ff) begin
         cur_in = (rnd > RW'(tpcs_pkg::CUR_POS_LIMIT)) ?
                  tpcs_pkg::CUR_W'(tpcs_pkg::CUR_POS_LIMIT) : rnd[tpcs_pkg::CUR_W-1:0];
      end else begin
         cur_in = (rnd > RW'(tpcs_pkg::CUR_NEG_LIMIT)) ?
                  tpcs_pkg::CUR_W'(tpcs_pkg::CUR_NEG_LIMIT) :
                  tpcs_pkg::CUR_W'(0) - rnd[tpcs_pkg::CUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         off_ff  <= MID_OFFSET;
      end else begin
         if (ctl.filt) begin
            filt_ff <= filt_in;
         end
         if (ctl.fin && ctl.track) begin
            off_ff <= off_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         px_ff  <= alpha * sample;
         plo_ff <= beta * filt_ff[LO_W-1:0];
         phi_ff <= beta * filt_ff[SW-1:LO_W];
      end
      if (ctl.prep) begin
         num_ff  <= num_w;
         dneg_ff <= diff[SW+1];
         mag_ff  <= (filt_ff >= off_ff) ? filt_ff - off_ff : off_ff - filt_ff;
         cneg_ff <= filt_ff < off_ff;
      end
      if (ctl.div) begin
         qlo_ff <= num_ff[NLO_W-1:0] * RECIP_100;
         qhi_ff <= num_ff[NW-1:NLO_W] * RECIP_100;
         clo_ff <= mag_ff[LO_W-1:0] * scale;
         chi_ff <= mag_ff[SW-1:LO_W] * scale;
      end
      if (ctl.fin) begin
         cur_ff <= cur_in;
      end
   end

   assign current = $signed(cur_ff);

endmodule

### design/tpcs_ctrl.sv
// tpcs_ctrl: per-request sequencer and calibration state (count, calibrated
// flag, phase decision). Depends on tpcs_pkg.

module tpcs_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_accept,
   input  logic                           slot_free,
   input  logic                           driver_ready,
   input  logic [tpcs_pkg::CNT_W-1:0]     calib_samples,
   output logic                           req_ready,
   output tpcs_pkg::lane_ctl_type         lane_ctl,
   output tpcs_pkg::merge_ctl_type        merge_ctl
);

   tpcs_pkg::ctrl_state_type state_ff, state_in;
   tpcs_pkg::phase_type      phase_ff, phase_w;
   logic [tpcs_pkg::CNT_W-1:0] count_ff, count_in;
   logic                     calibrated_ff, calibrated_in;

   always_comb begin
      if (driver_ready && !calibrated_ff) begin
         phase_w = (count_ff < calib_samples) ? tpcs_pkg::PH_CALIB : tpcs_pkg::PH_DONE;
      end else if (driver_ready) begin
         phase_w = tpcs_pkg::PH_MEASURE;
      end else begin
         phase_w = tpcs_pkg::PH_OFF;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpcs_pkg::ST_IDLE: begin
            if (req_accept) state_in = tpcs_pkg::ST_MUL;
         end
         tpcs_pkg::ST_MUL:  state_in = tpcs_pkg::ST_FILT;
         tpcs_pkg::ST_FILT: state_in = tpcs_pkg::ST_PREP;
         tpcs_pkg::ST_PREP: state_in = tpcs_pkg::ST_DIV;
         tpcs_pkg::ST_DIV:  state_in = tpcs_pkg::ST_FIN;
         tpcs_pkg::ST_FIN:  state_in = tpcs_pkg::ST_OUT;
         tpcs_pkg::ST_OUT: begin
            if (slot_free) state_in = tpcs_pkg::ST_IDLE;
         end
         default: state_in = tpcs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = state_ff == tpcs_pkg::ST_IDLE;
      lane_ctl.mul      = state_ff == tpcs_pkg::ST_MUL;
      lane_ctl.filt     = state_ff == tpcs_pkg::ST_FILT;
      lane_ctl.prep     = state_ff == tpcs_pkg::ST_PREP;
      lane_ctl.div      = state_ff == tpcs_pkg::ST_DIV;
      lane_ctl.fin      = state_ff == tpcs_pkg::ST_FIN;
      lane_ctl.track    = phase_w == tpcs_pkg::PH_CALIB;
      merge_ctl.bus_mul = state_ff == tpcs_pkg::ST_MUL;
      merge_ctl.bus_upd = (state_ff == tpcs_pkg::ST_FIN) && (phase_w == tpcs_pkg::PH_MEASURE);
      merge_ctl.load    = state_ff == tpcs_pkg::ST_OUT;
      merge_ctl.phase   = phase_ff;
   end

   // calibration bookkeeping, committed once per request
   always_comb begin
      count_in      = count_ff;
      calibrated_in = calibrated_ff;
      if (state_ff == tpcs_pkg::ST_FIN) begin
         if (phase_w == tpcs_pkg::PH_CALIB) begin
            count_in = count_ff + tpcs_pkg::CNT_W'(1);
         end else if (phase_w == tpcs_pkg::PH_DONE) begin
            count_in      = '0;
            calibrated_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tpcs_pkg::ST_IDLE;
         count_ff      <= '0;
         calibrated_ff <= 1'b0;
         phase_ff      <= tpcs_pkg::PH_OFF;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         calibrated_ff <= calibrated_in;
         if (state_ff == tpcs_pkg::ST_FIN) begin
            phase_ff <= phase_w;
         end
      end
   end

endmodule

### design/tpcs_merge.sv
// tpcs_merge: bus voltage scaling and clamp, integrator limit, and the result
// register that combines the three lanes. Depends on tpcs_pkg, tpcs_ifs.

module tpcs_merge #(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tpcs_pkg::merge_ctl_type           ctl,
   input  logic [ADC_BITS-1:0]               sample_bus,
   input  logic [tpcs_pkg::SCALE_W-1:0]      volt_scale,
   input  logic [tpcs_pkg::BUS_W-1:0]        supply_limit,
   input  logic signed [tpcs_pkg::CUR_W-1:0] cur_a,
   input  logic signed [tpcs_pkg::CUR_W-1:0] cur_b,
   input  logic signed [tpcs_pkg::CUR_W-1:0] cur_c,
   output logic                              slot_free,
   tpcs_rsp_if.source                        rsp
);

   localparam int VSH   = tpcs_pkg::SCALE_W - FRAC_BITS;
   localparam int VHALF = (2 ** VSH) / 2;
   localparam int BP_W  = ADC_BITS + tpcs_pkg::SCALE_W + 1;
   localparam int IP_W  = tpcs_pkg::BUS_W + tpcs_pkg::INTEG_W + 1;

   logic [BP_W-1:0]                bus_prod_ff;
   logic [BP_W-1:0]                volts;
   logic [tpcs_pkg::BUS_W-1:0]     last_bus_ff, last_bus_in;
   logic [IP_W-1:0]                integ;
   logic                           rsp_valid_ff;
   logic                           load;
   logic                           measuring;
   logic [tpcs_pkg::CUR_W-1:0]     rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic [tpcs_pkg::BUS_W-1:0]     rsp_bus_ff, rsp_integ_ff;
   tpcs_pkg::phase_type            rsp_phase_ff;

   assign volts       = (bus_prod_ff + BP_W'(VHALF)) >> VSH;
   assign last_bus_in = (volts > BP_W'(supply_limit)) ? supply_limit
                                                      : volts[tpcs_pkg::BUS_W-1:0];
   assign integ       = (IP_W'(last_bus_ff) * IP_W'(tpcs_pkg::INTEG_GAIN)
                        + IP_W'(tpcs_pkg::Q16_ROUND)) >> 16;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign load      = ctl.load && slot_free;
   assign measuring = ctl.phase == tpcs_pkg::PH_MEASURE;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_bus_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.bus_upd) begin
            last_bus_ff <= last_bus_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.bus_mul) begin
         bus_prod_ff <= sample_bus * volt_scale;
      end
      if (load) begin
         rsp_a_ff     <= measuring ? cur_a : '0;
         rsp_b_ff     <= measuring ? cur_b : '0;
         rsp_c_ff     <= measuring ? cur_c : '0;
         rsp_bus_ff   <= last_bus_ff;
         rsp_integ_ff <= integ[tpcs_pkg::BUS_W-1:0];
         rsp_phase_ff <= ctl.phase;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.current_a   = $signed(rsp_a_ff);
   assign rsp.current_b   = $signed(rsp_b_ff);
   assign rsp.current_c   = $signed(rsp_c_ff);
   assign rsp.bus_volts   = rsp_bus_ff;
   assign rsp.integ_limit = rsp_integ_ff;
   assign rsp.phase       = rsp_phase_ff;

endmodule

### design/three_phase_current_sense_frontend.sv
// three_phase_current_sense_frontend: top level - register file, request
// register, three phase lanes, sequencer and result merge.
// Depends on tpcs_pkg, tpcs_ifs, tpcs_lane, tpcs_ctrl, tpcs_merge.
//
// usage
//  - req_chan carries one request: three phase current samples and a bus
//    voltage sample. csr_chan writes the six registers (index 0 driver_ready
//    to 5 supply_limit); it is always ready, indexes past 5 are dropped.
//  - rsp_chan gives exactly one result per request.
//  - one request is processed at a time: req ready is high only while the
//    sequencer is idle. a request steps through filter multiply, filter
//    update, prep, the divide and scale multiplies, finish and output load,
//    then returns to idle to accept again.
//  - the result sits in an output register; the next request is accepted
//    while it waits, and that request holds in its last step until the
//    register is taken.
//  - reset (synchronous, active high) restores the register defaults, clears
//    the filters, sets offsets to mid-scale and restarts calibration.

module three_phase_current_sense_frontend #(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tpcs_req_if.sink    req_chan,
   tpcs_rsp_if.source  rsp_chan,
   tpcs_csr_if.sink    csr_chan
);

   // configuration registers
   logic                              driver_ready_ff;
   logic [tpcs_pkg::ALPHA_W-1:0]      filter_alpha_ff;
   logic [tpcs_pkg::CNT_W-1:0]        calib_samples_ff;
   logic [tpcs_pkg::SCALE_W-1:0]      current_scale_ff;
   logic [tpcs_pkg::SCALE_W-1:0]      volt_scale_ff;
   logic [tpcs_pkg::BUS_W-1:0]        supply_limit_ff;

   // request register, held for the whole request
   logic [ADC_BITS-1:0] sample_a_ff, sample_b_ff, sample_c_ff, sample_bus_ff;

   logic                        req_ready;
   logic                        req_accept;
   logic                        slot_free;
   tpcs_pkg::lane_ctl_type      lane_ctl;
   tpcs_pkg::merge_ctl_type     merge_ctl;
   logic signed [tpcs_pkg::CUR_W-1:0] cur_a, cur_b, cur_c;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign req_accept     = req_chan.valid && req_ready;

   // register writes, each value cut to its register width
   always_ff @(posedge clock) begin
      if (reset) begin
         driver_ready_ff  <= tpcs_pkg::DRIVER_READY_RST;
         filter_alpha_ff  <= tpcs_pkg::FILTER_ALPHA_RST;
         calib_samples_ff <= tpcs_pkg::CALIB_SAMPLES_RST;
         current_scale_ff <= tpcs_pkg::CURRENT_SCALE_RST;
         volt_scale_ff    <= tpcs_pkg::VOLT_SCALE_RST;
         supply_limit_ff  <= tpcs_pkg::SUPPLY_LIMIT_RST;
      end else if (csr_chan.valid) begin
         case (tpcs_pkg::csr_index_type'(csr_chan.index))
            tpcs_pkg::REG_DRIVER_READY:  driver_ready_ff  <= csr_chan.data[0];
            tpcs_pkg::REG_FILTER_ALPHA:  filter_alpha_ff  <= csr_chan.data[tpcs_pkg::ALPHA_W-1:0];
            tpcs_pkg::REG_CALIB_SAMPLES: calib_samples_ff <= csr_chan.data[tpcs_pkg::CNT_W-1:0];
            tpcs_pkg::REG_CURRENT_SCALE: current_scale_ff <= csr_chan.data[tpcs_pkg::SCALE_W-1:0];
            tpcs_pkg::REG_VOLT_SCALE:    volt_scale_ff    <= csr_chan.data[tpcs_pkg::SCALE_W-1:0];
            tpcs_pkg::REG_SUPPLY_LIMIT:  supply_limit_ff  <= csr_chan.data[tpcs_pkg::BUS_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // capture the samples on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_a_ff   <= req_chan.sample_a;
         sample_b_ff   <= req_chan.sample_b;
         sample_c_ff   <= req_chan.sample_c;
         sample_bus_ff <= req_chan.sample_bus;
      end
   end

   // sequencer and calibration state
   tpcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .slot_free     (slot_free),
      .driver_ready  (driver_ready_ff),
      .calib_samples (calib_samples_ff),
      .req_ready     (req_ready),
      .lane_ctl      (lane_ctl),
      .merge_ctl     (merge_ctl)
   );

   // one lane per phase, all driven by the same control
   tpcs_lane #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_a (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (sample_a_ff),
      .alpha   (filter_alpha_ff),
      .scale   (current_scale_ff),
      .current (cur_a)
   );

   tpcs_lane #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_b (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (sample_b_ff),
      .alpha   (filter_alpha_ff),
      .scale   (current_scale_ff),
      .current (cur_b)
   );

   tpcs_lane #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_c (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (sample_c_ff),
      .alpha   (filter_alpha_ff),
      .scale   (current_scale_ff),
      .current (cur_c)
   );

   // bus voltage path and result register
   tpcs_merge #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (merge_ctl),
      .sample_bus   (sample_bus_ff),
      .volt_scale   (volt_scale_ff),
      .supply_limit (supply_limit_ff),
      .cur_a        (cur_a),
      .cur_b        (cur_b),
      .cur_c        (cur_c),
      .slot_free    (slot_free),
      .rsp          (rsp_chan)
   );

endmodule

### tb/tpcs_result_checker.sv
`timescale 1ns / 100ps
// tpcs_result_checker: watches the request, result and register channels of the
// current sense front end, predicts each result and compares it field by field.
// Depends on tpcs_pkg and tpcs_ifs.

module tpcs_result_checker import tpcs_pkg::*; #(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tpcs_req_if         req_mon,
   tpcs_rsp_if         rsp_mon,
   tpcs_csr_if         csr_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   localparam int STORE_W      = ADC_BITS + FRAC_BITS;
   localparam int VOLT_SH      = 24 - FRAC_BITS;
   localparam int REPORT_LIMIT = 10;
   localparam logic [63:0] VOLT_HALF   = (VOLT_SH > 0) ? (64'd1 << (VOLT_SH - 1)) : 64'd0;
   localparam logic [63:0] MID_SCALE   = 64'd1 << (ADC_BITS - 1 + FRAC_BITS);
   localparam logic [63:0] AMP_POS_MAX = (64'd1 << (CUR_W - 1)) - 64'd1;
   localparam logic [63:0] AMP_NEG_MAX = 64'd1 << (CUR_W - 1);
   localparam logic [63:0] INTEG_Q16   = 64'd30270;   // 0.8/sqrt(3)

   typedef logic [STORE_W-1:0] counts_t;

   typedef struct packed {
      logic signed [CUR_W-1:0] current_a;
      logic signed [CUR_W-1:0] current_b;
      logic signed [CUR_W-1:0] current_c;
      logic [BUS_W-1:0]        bus_volts;
      logic [BUS_W-1:0]        integ_limit;
      phase_type               phase;
   } sense_result_t;

   // register copies
   logic               drv_ready;
   logic [ALPHA_W-1:0] alpha;
   logic [CNT_W-1:0]   calib_len;
   logic [SCALE_W-1:0] amp_scale;
   logic [SCALE_W-1:0] volt_gain;
   logic [BUS_W-1:0]   volt_cap;

   // front end state
   counts_t            filt [3];
   counts_t            offs [3];
   logic [CNT_W-1:0]   calib_cnt;
   logic               calib_done;
   logic [BUS_W-1:0]   held_bus;

   sense_result_t      expected_q [$];

   function automatic counts_t smooth(counts_t prev, logic [ADC_BITS-1:0] raw,
                                      logic [ALPHA_W-1:0] a);
      logic [63:0] acc;
      acc = 64'(a) * (64'(raw) << FRAC_BITS) + (64'd65536 - 64'(a)) * 64'(prev) + 64'd32768;
      return counts_t'(acc >> 16);
   endfunction

   // 0.99/0.01 running average with rounding
   function automatic counts_t follow(counts_t off, counts_t f);
      return counts_t'((64'(off) * 64'd99 + 64'(f) + 64'd50) / 64'd100);
   endfunction

   function automatic logic signed [CUR_W-1:0] to_amps(counts_t f, counts_t off);
      logic        below;
      logic [63:0] mag;
      logic [63:0] amp;
      below = f < off;
      mag   = below ? 64'(off - f) : 64'(f - off);
      amp   = (mag * 64'(amp_scale) + 64'd8388608) >> 24;
      if (below)
         return (amp > AMP_NEG_MAX) ? CUR_W'(64'd0 - AMP_NEG_MAX) : CUR_W'(64'd0 - amp);
      return (amp > AMP_POS_MAX) ? CUR_W'(AMP_POS_MAX) : CUR_W'(amp);
   endfunction

   task automatic apply_write();
      case (csr_mon.index)
         REG_DRIVER_READY:  drv_ready = csr_mon.data[0];
         REG_FILTER_ALPHA:  alpha     = csr_mon.data[ALPHA_W-1:0];
         REG_CALIB_SAMPLES: calib_len = csr_mon.data[CNT_W-1:0];
         REG_CURRENT_SCALE: amp_scale = csr_mon.data[SCALE_W-1:0];
         REG_VOLT_SCALE:    volt_gain = csr_mon.data[SCALE_W-1:0];
         REG_SUPPLY_LIMIT:  volt_cap  = csr_mon.data[BUS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic record_request();
      logic [ADC_BITS-1:0] raw [3];
      sense_result_t       want;
      logic [63:0]         volts;
      raw[0] = req_mon.sample_a;
      raw[1] = req_mon.sample_b;
      raw[2] = req_mon.sample_c;
      want = '0;
      want.phase = PH_OFF;
      for (int p = 0; p < 3; p++)
         filt[p] = smooth(filt[p], raw[p], alpha);
      if (drv_ready && !calib_done) begin
         if (calib_cnt < calib_len) begin
            for (int p = 0; p < 3; p++)
               offs[p] = follow(offs[p], filt[p]);
            calib_cnt++;
            want.phase = PH_CALIB;
         end else begin
            calib_done = 1'b1;
            calib_cnt  = '0;
            want.phase = PH_DONE;
         end
      end else if (drv_ready) begin
         volts = (64'(req_mon.sample_bus) * 64'(volt_gain) + VOLT_HALF) >> VOLT_SH;
         if (volts > 64'(volt_cap))
            volts = 64'(volt_cap);
         held_bus       = BUS_W'(volts);
         want.current_a = to_amps(filt[0], offs[0]);
         want.current_b = to_amps(filt[1], offs[1]);
         want.current_c = to_amps(filt[2], offs[2]);
         want.phase     = PH_MEASURE;
      end
      want.bus_volts   = held_bus;
      want.integ_limit = BUS_W'((64'(held_bus) * INTEG_Q16 + 64'd32768) >> 16);
      expected_q.push_back(want);
   endtask

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      sense_result_t want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding", $time);
      end else begin
         want = expected_q.pop_front();
         check_field("current_a", want.current_a, rsp_mon.current_a);
         check_field("current_b", want.current_b, rsp_mon.current_b);
         check_field("current_c", want.current_c, rsp_mon.current_c);
         check_field("bus_volts", want.bus_volts, rsp_mon.bus_volts);
         check_field("integ_limit", want.integ_limit, rsp_mon.integ_limit);
         check_field("phase", want.phase, rsp_mon.phase);
      end
   endtask

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         drv_ready = DRIVER_READY_RST;
         alpha     = FILTER_ALPHA_RST;
         calib_len = CALIB_SAMPLES_RST;
         amp_scale = CURRENT_SCALE_RST;
         volt_gain = VOLT_SCALE_RST;
         volt_cap  = SUPPLY_LIMIT_RST;
         for (int p = 0; p < 3; p++) begin
            filt[p] = '0;
            offs[p] = counts_t'(MID_SCALE);
         end
         calib_cnt  = '0;
         calib_done = 1'b0;
         held_bus   = '0;
         expected_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            apply_write();
         if (req_mon.valid && req_mon.ready)
            record_request();
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      outstanding = expected_q.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus, watchdog and verdict for three_phase_current_sense_frontend.
// Depends on tpcs_pkg, tpcs_ifs, the design and tpcs_result_checker.

module tb;
   import tpcs_pkg::*;

   localparam int ADC_BITS       = 12;
   localparam int FRAC_BITS      = 16;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 20;
   localparam int STALL_LIMIT    = 2000;   // cycles with no handshake at all
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 95;
   localparam int MAX_GAP        = 7;

   localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
   localparam logic [ADC_BITS-1:0] ADC_MID = ADC_BITS'(1) << (ADC_BITS - 1);

   // register field masks inside the write data
   localparam logic [CSR_DATA_W-1:0] BIT_MASK    = 24'h000001;
   localparam logic [CSR_DATA_W-1:0] ALPHA_MASK  = 24'h00ffff;
   localparam logic [CSR_DATA_W-1:0] SCALE_MASK  = 24'hffffff;
   localparam logic [CSR_DATA_W-1:0] SUPPLY_MASK = 24'h3fffff;
   localparam logic [CSR_DATA_W-1:0] NO_MASK     = 24'h000000;

   // indexes past the register list, the block drops these writes
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   bit          req_calm;    // when set the request side sends back to back
   bit          rsp_calm;    // when set results are taken without stalls

   tpcs_req_if #(.ADC_BITS(ADC_BITS)) req_if ();
   tpcs_rsp_if                        rsp_if ();
   tpcs_csr_if                        csr_if ();

   three_phase_current_sense_frontend #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predicts every result and counts mismatches
   tpcs_result_checker #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int unsigned draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // partly near mid-scale so currents stay unsaturated, with rail and full-range values mixed in
   function automatic logic [ADC_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ADC_MAX;
         2, 3, 4: return ADC_MID - ADC_BITS'(100) + ADC_BITS'($urandom_range(0, 200));
         default: return ADC_BITS'($urandom_range(0, ADC_MAX));
      endcase
   endfunction

   // register value: zero, all ones, reset value or random
   function automatic logic [CSR_DATA_W-1:0] choose_setting(logic [CSR_DATA_W-1:0] mask,
                                                            logic [CSR_DATA_W-1:0] dflt);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return mask;
         2: return dflt;
         default: return CSR_DATA_W'($urandom()) & mask;
      endcase
   endfunction

   // register write; bits above the field carry noise the block must mask off
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value,
                            logic [CSR_DATA_W-1:0] mask);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= (value & mask) | (CSR_DATA_W'($urandom()) & ~mask);
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // one request, with a random hold-off before valid goes up
   task automatic send_request(logic [ADC_BITS-1:0] a, b, c, bus);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         req_calm = !req_calm;
      gap = draw_gap(req_calm);
      csr_if.valid <= 1'b0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sample_a   <= a;
      req_if.sample_b   <= b;
      req_if.sample_c   <= c;
      req_if.sample_bus <= bus;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_random();
      send_request(random_sample(), random_sample(), random_sample(), random_sample());
   endtask

   // registers only change once every result is back and the pipe is empty
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stall per result, with calm stretches
   initial begin : result_drain
      int unsigned stall;
      rsp_if.ready = 1'b0;
      rsp_calm     = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_calm = !rsp_calm;
         stall = draw_gap(rsp_calm);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // ends the run when no channel moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** three_phase_current_sense_frontend: FAILED **");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.sample_a   = '0;
      req_if.sample_b   = '0;
      req_if.sample_c   = '0;
      req_if.sample_bus = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      req_calm          = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short calibration with the filter passing samples straight through
      csr_write(REG_CALIB_SAMPLES, 24'd6, ALPHA_MASK);
      csr_write(REG_FILTER_ALPHA, ALPHA_MASK, ALPHA_MASK);
      send_request('0, '0, '0, '0);
      send_request(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX);

      // driver dropped mid calibration: filters run, offsets and count hold
      wait_idle();
      csr_write(REG_DRIVER_READY, 24'd0, BIT_MASK);
      send_request(ADC_MAX, '0, ADC_MID, ADC_MAX);
      send_request('0, ADC_MAX, 12'd1, ADC_MAX);

      // calibration resumes; a zero alpha freezes the filters
      wait_idle();
      csr_write(REG_DRIVER_READY, 24'd1, BIT_MASK);
      csr_write(REG_FILTER_ALPHA, 24'd0, ALPHA_MASK);
      send_request(12'd1234, 12'd2345, 12'd3456, 12'd100);
      wait_idle();
      csr_write(REG_FILTER_ALPHA, 24'd32768, ALPHA_MASK);
      send_request(ADC_MID, ADC_MID - 12'd1, ADC_MID + 12'd1, '0);

      // sample count dropped below the running count: next request ends calibration
      wait_idle();
      csr_write(REG_CALIB_SAMPLES, 24'd0, ALPHA_MASK);
      send_request(ADC_MID, ADC_MID, ADC_MID, ADC_MID);

      // full scales: currents saturate both ways, bus clamps at the top
      wait_idle();
      csr_write(REG_CURRENT_SCALE, SCALE_MASK, SCALE_MASK);
      csr_write(REG_VOLT_SCALE, SCALE_MASK, SCALE_MASK);
      csr_write(REG_SUPPLY_LIMIT, SUPPLY_MASK, SUPPLY_MASK);
      csr_write(REG_FILTER_ALPHA, ALPHA_MASK, ALPHA_MASK);
      csr_write(REG_SPARE_6, 24'd0, NO_MASK);
      csr_write(REG_SPARE_7, 24'd0, NO_MASK);
      send_request(ADC_MAX, '0, ADC_MAX, ADC_MAX);
      send_request('0, ADC_MAX, '0, '0);
      send_request(ADC_MAX, '0, ADC_MID, ADC_MAX);

      // zero scales and a zero supply limit
      wait_idle();
      csr_write(REG_SUPPLY_LIMIT, 24'd0, SUPPLY_MASK);
      csr_write(REG_CURRENT_SCALE, 24'd0, SCALE_MASK);
      csr_write(REG_VOLT_SCALE, 24'd0, SCALE_MASK);
      send_request(ADC_MAX, '0, ADC_MID, ADC_MAX);

      // reset values back, calibration count at its top
      wait_idle();
      csr_write(REG_CURRENT_SCALE, CURRENT_SCALE_RST, SCALE_MASK);
      csr_write(REG_VOLT_SCALE, VOLT_SCALE_RST, SCALE_MASK);
      csr_write(REG_SUPPLY_LIMIT, CSR_DATA_W'(SUPPLY_LIMIT_RST), SUPPLY_MASK);
      csr_write(REG_FILTER_ALPHA, CSR_DATA_W'(FILTER_ALPHA_RST), ALPHA_MASK);
      csr_write(REG_CALIB_SAMPLES, ALPHA_MASK, ALPHA_MASK);
      send_request(ADC_MAX, ADC_MID, '0, ADC_MAX);
      send_request(ADC_MID + 12'd40, ADC_MID - 12'd40, ADC_MID, 12'd2000);
      send_request('0, ADC_MAX, ADC_MID, 12'd3000);

      // driver dropped while measuring: currents zero, bus value held
      wait_idle();
      csr_write(REG_DRIVER_READY, 24'd0, BIT_MASK);
      send_request(ADC_MAX, ADC_MAX, '0, '0);
      send_request('0, '0, ADC_MAX, ADC_MAX);

      // random phases, each with a fresh register setting
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         wait_idle();
         csr_write(REG_DRIVER_READY, (k % 4 == 3) ? 24'd0 : 24'd1, BIT_MASK);
         csr_write(REG_FILTER_ALPHA,
                   choose_setting(ALPHA_MASK, CSR_DATA_W'(FILTER_ALPHA_RST)), ALPHA_MASK);
         csr_write(REG_CALIB_SAMPLES,
                   choose_setting(ALPHA_MASK, CSR_DATA_W'(CALIB_SAMPLES_RST)), ALPHA_MASK);
         csr_write(REG_CURRENT_SCALE, choose_setting(SCALE_MASK, CURRENT_SCALE_RST),
                   SCALE_MASK);
         csr_write(REG_VOLT_SCALE, choose_setting(SCALE_MASK, VOLT_SCALE_RST), SCALE_MASK);
         csr_write(REG_SUPPLY_LIMIT,
                   choose_setting(SUPPLY_MASK, CSR_DATA_W'(SUPPLY_LIMIT_RST)), SUPPLY_MASK);
         if (k % 3 == 0)
            csr_write((k % 2 == 0) ? REG_SPARE_6 : REG_SPARE_7, 24'd0, NO_MASK);
         repeat (PHASE_REQUESTS) send_random();
      end

      // drain, let the pipe settle, then the verdict
      wait_idle();
      if (mismatches == 0 && outstanding == 0)
         $display("** three_phase_current_sense_frontend: PASSED **");
      else
         $display("** three_phase_current_sense_frontend: FAILED **");
      $finish;
   end

endmodule

### files.f
design/tpcs_pkg.sv
design/tpcs_ifs.sv
design/tpcs_lane.sv
design/tpcs_ctrl.sv
design/tpcs_merge.sv
design/three_phase_current_sense_frontend.sv
tb/tpcs_result_checker.sv
tb/tb.sv
